### hw/rtl/bwe_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bwe_pkg
// Shared types, constants and helpers of the box wireframe edge generator.
// ============================================================================
package bwe_pkg;

    localparam int MAX_LINES_DEF   = 1024;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int COORD_W         = 32;
    localparam int COLOR_W         = 32;
    localparam int SLOT_W          = 10;
    localparam int EDGE_W          = 4;
    localparam int CORNER_W        = 3;

    localparam logic [EDGE_W-1:0] EDGE_FIRST = 4'd0;
    localparam logic [EDGE_W-1:0] EDGE_LAST  = 4'd11;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0]        color_t;
    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic [EDGE_W-1:0]         edge_idx_t;
    typedef logic [CORNER_W-1:0]       corner_t;

    typedef enum logic
    {
        CMD_ADD   = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t   cmd;
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
        color_t color;
    } qentry_t;

    function automatic coord_t sat_sum(input coord_t a, input coord_t b, input logic sub);
        logic signed [COORD_W:0] ea;
        logic signed [COORD_W:0] eb;
        logic signed [COORD_W:0] s;
        coord_t                  r;
        ea = {a[COORD_W-1], a};
        eb = {b[COORD_W-1], b};
        s  = sub ? (ea - eb) : (ea + eb);
        if (s[COORD_W] != s[COORD_W-1])
        begin
            r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic corner_t edge_from(input edge_idx_t e);
        corner_t c;
        unique case (e)
            4'd0:    c = 3'd0;
            4'd1:    c = 3'd0;
            4'd2:    c = 3'd0;
            4'd3:    c = 3'd1;
            4'd4:    c = 3'd1;
            4'd5:    c = 3'd2;
            4'd6:    c = 3'd2;
            4'd7:    c = 3'd3;
            4'd8:    c = 3'd4;
            4'd9:    c = 3'd4;
            4'd10:   c = 3'd5;
            4'd11:   c = 3'd6;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic corner_t edge_to(input edge_idx_t e);
        corner_t c;
        unique case (e)
            4'd0:    c = 3'd1;
            4'd1:    c = 3'd2;
            4'd2:    c = 3'd4;
            4'd3:    c = 3'd3;
            4'd4:    c = 3'd5;
            4'd5:    c = 3'd3;
            4'd6:    c = 3'd6;
            4'd7:    c = 3'd7;
            4'd8:    c = 3'd5;
            4'd9:    c = 3'd6;
            4'd10:   c = 3'd7;
            4'd11:   c = 3'd7;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/bwe_front.sv
`timescale 1ns / 1ps
// ============================================================================
// bwe_front
// Accepts input words, forms the saturated low and high corners of a box
// and holds one classified entry for the queue.
// ============================================================================
module bwe_front
    import bwe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    cmd,
    input  coord_t  center_x,
    input  coord_t  center_y,
    input  coord_t  center_z,
    input  coord_t  half_x,
    input  coord_t  half_y,
    input  coord_t  half_z,
    input  color_t  color,
    output logic    entry_valid,
    input  logic    entry_ready,
    output qentry_t entry
);

    logic    valid_reg;
    logic    valid_next;
    qentry_t entry_reg;
    qentry_t entry_next;
    logic    accept;

    assign in_ready    = !valid_reg || entry_ready;
    assign accept      = in_valid && in_ready;
    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

    always_comb
    begin
        entry_next.cmd   = cmd_t'(cmd);
        entry_next.lo_x  = sat_sum(center_x, half_x, 1'b1);
        entry_next.lo_y  = sat_sum(center_y, half_y, 1'b1);
        entry_next.lo_z  = sat_sum(center_z, half_z, 1'b1);
        entry_next.hi_x  = sat_sum(center_x, half_x, 1'b0);
        entry_next.hi_y  = sat_sum(center_y, half_y, 1'b0);
        entry_next.hi_z  = sat_sum(center_z, half_z, 1'b0);
        entry_next.color = color;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (entry_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### hw/rtl/bwe_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// bwe_queue
// Short first-in first-out queue of classified entries between the front
// and the back.
// ============================================================================
module bwe_queue
    import bwe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  qentry_t push_data,
    output logic    head_valid,
    input  logic    head_pop,
    output qentry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = head_pop && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/bwe_back.sv
`timescale 1ns / 1ps
// ============================================================================
// bwe_back
// Walks the twelve wireframe lines of the queue head, assigns line slots from the
// line count and drives the registered result word.
// ============================================================================
module bwe_back
    import bwe_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  qentry_t head,
    output logic    head_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output coord_t  start_x,
    output coord_t  start_y,
    output coord_t  start_z,
    output coord_t  end_x,
    output coord_t  end_y,
    output coord_t  end_z,
    output color_t  line_color,
    output slot_t   slot,
    output logic    stored,
    output logic    last
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);

    logic             out_valid_reg;
    logic             out_valid_next;
    edge_idx_t        edge_reg;
    edge_idx_t        edge_next;
    logic [CNT_W-1:0] line_count_reg;
    logic [CNT_W-1:0] line_count_next;
    coord_t           start_x_reg;
    coord_t           start_y_reg;
    coord_t           start_z_reg;
    coord_t           end_x_reg;
    coord_t           end_y_reg;
    coord_t           end_z_reg;
    color_t           line_color_reg;
    slot_t            slot_reg;
    slot_t            slot_next;
    logic             stored_reg;
    logic             last_reg;
    logic             load_en;
    logic             issue;
    logic             clear;
    logic             has_room;
    corner_t          c_from;
    corner_t          c_to;

    assign load_en  = !out_valid_reg || out_ready;
    assign issue    = head_valid && (head.cmd == CMD_ADD) && load_en;
    assign clear    = head_valid && (head.cmd == CMD_CLEAR);
    assign head_pop = clear || (issue && (edge_reg == EDGE_LAST));
    assign has_room = (line_count_reg < CNT_W'(MAX_LINES));
    assign c_from   = edge_from(edge_reg);
    assign c_to     = edge_to(edge_reg);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        edge_next       = edge_reg;
        line_count_next = line_count_reg;
        slot_next       = '0;
        if (has_room)
        begin
            slot_next = SLOT_W'(line_count_reg);
        end
        if (issue)
        begin
            out_valid_next = 1'b1;
            edge_next      = (edge_reg == EDGE_LAST) ? EDGE_FIRST : edge_reg + 1'b1;
            if (has_room)
            begin
                line_count_next = line_count_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (clear)
        begin
            line_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            edge_reg       <= EDGE_FIRST;
            line_count_reg <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            edge_reg       <= edge_next;
            line_count_reg <= line_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            start_x_reg    <= c_from[0] ? head.hi_x : head.lo_x;
            start_y_reg    <= c_from[1] ? head.hi_y : head.lo_y;
            start_z_reg    <= c_from[2] ? head.hi_z : head.lo_z;
            end_x_reg      <= c_to[0] ? head.hi_x : head.lo_x;
            end_y_reg      <= c_to[1] ? head.hi_y : head.lo_y;
            end_z_reg      <= c_to[2] ? head.hi_z : head.lo_z;
            line_color_reg <= head.color;
            slot_reg       <= slot_next;
            stored_reg     <= has_room;
            last_reg       <= (edge_reg == EDGE_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign start_x    = start_x_reg;
    assign start_y    = start_y_reg;
    assign start_z    = start_z_reg;
    assign end_x      = end_x_reg;
    assign end_y      = end_y_reg;
    assign end_z      = end_z_reg;
    assign line_color = line_color_reg;
    assign slot       = slot_reg;
    assign stored     = stored_reg;
    assign last       = last_reg;

endmodule

### hw/rtl/box_wireframe_edge_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// box_wireframe_edge_generator
// Turns an axis-aligned box into its twelve wireframe lines, each tagged
// with the line slot it fills.
//
//   Channel  Handshake            Word
//   input    in_valid / in_ready  cmd, center_x..z, half_x..z, color
//   output   out_valid/out_ready  start_x..z, end_x..z, line_color, slot,
//                                 stored, last
//
// A box yields one edge per cycle while out_ready holds, paced by the
// single output register. A clear word yields nothing. An input word
// passes the front register, the queue and the output register before
// its first edge appears. Reset zeroes the line count and empties the
// pipeline. The queue lets the front take words while the output stalls.
// ============================================================================
module box_wireframe_edge_generator
    import bwe_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  logic   cmd,
    input  coord_t center_x,
    input  coord_t center_y,
    input  coord_t center_z,
    input  coord_t half_x,
    input  coord_t half_y,
    input  coord_t half_z,
    input  color_t color,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t start_x,
    output coord_t start_y,
    output coord_t start_z,
    output coord_t end_x,
    output coord_t end_y,
    output coord_t end_z,
    output color_t line_color,
    output slot_t  slot,
    output logic   stored,
    output logic   last
);

    logic    entry_valid;
    logic    entry_ready;
    qentry_t entry;
    logic    head_valid;
    logic    head_pop;
    qentry_t head;

    bwe_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .half_x      (half_x),
        .half_y      (half_y),
        .half_z      (half_z),
        .color       (color),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .entry       (entry)
    );

    bwe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (entry_valid),
        .push_ready (entry_ready),
        .push_data  (entry),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head       (head)
    );

    bwe_back #(
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_z    (start_z),
        .end_x      (end_x),
        .end_y      (end_y),
        .end_z      (end_z),
        .line_color (line_color),
        .slot       (slot),
        .stored     (stored),
        .last       (last)
    );

endmodule
